// ===== sv/rgbhsv_pkg.sv =====
// Shared types and the reciprocal table for the RGB to HSV converter.
`timescale 1ns / 1ps

package rgbhsv_pkg;

    // Width of the hue sector offset term (up to six times an 8-bit delta)
    localparam int K_W = 11;

    // Stage-one results handed from the channel compare to the dividers
    typedef struct packed {
        logic           valid;
        logic [7:0]     mx;
        logic [7:0]     delta;
        logic [K_W-1:0] k;
    } ext_t;

    // Reciprocal of each 8-bit divisor from 2 up, scaled by 2^32 and rounded down; 1 gives all ones, 0 gives 0
    typedef logic [31:0] recip_tab_t [256];

    function automatic recip_tab_t build_recip_tab();
        recip_tab_t  tab;
        logic [32:0] one_q;
        one_q  = 33'h1_0000_0000;
        tab[0] = '0;
        tab[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 256; i++)
        begin
            tab[i] = 32'(one_q / 33'(i));
        end
        return tab;
    endfunction

    localparam recip_tab_t RECIP_TAB = build_recip_tab();

endpackage

// ===== sv/rgbhsv_extract.sv =====
// Channel compare stage: maximum, spread and hue sector numerator term.
`timescale 1ns / 1ps

module rgbhsv_extract
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  logic [7:0]          red,
    input  logic [7:0]          green,
    input  logic [7:0]          blue,
    output rgbhsv_pkg::ext_t    ext
);

    rgbhsv_pkg::ext_t ext_reg;
    rgbhsv_pkg::ext_t ext_next;

    logic [7:0]         mx;
    logic [7:0]         mn;
    logic [7:0]         delta;
    logic signed [11:0] diff_s;
    logic signed [11:0] base_s;
    logic signed [11:0] k_full;

    // Find the extremes and pick the sector, red first, then green
    always_comb
    begin
        mx     = (red > green) ? red : green;
        mx     = (mx > blue) ? mx : blue;
        mn     = (red < green) ? red : green;
        mn     = (mn < blue) ? mn : blue;
        delta  = mx - mn;
        diff_s = '0;
        base_s = '0;
        if (mx == red)
        begin
            diff_s = $signed({4'b0, green}) - $signed({4'b0, blue});
            if (diff_s < 0)
            begin
                base_s = $signed({4'b0, delta} << 2) + $signed({4'b0, delta} << 1);
            end
        end
        else if (mx == green)
        begin
            diff_s = $signed({4'b0, blue}) - $signed({4'b0, red});
            base_s = $signed({4'b0, delta} << 1);
        end
        else
        begin
            diff_s = $signed({4'b0, red}) - $signed({4'b0, green});
            base_s = $signed({4'b0, delta} << 2);
        end
        k_full         = diff_s + base_s;
        ext_next.valid = load;
        ext_next.mx    = mx;
        ext_next.delta = delta;
        ext_next.k     = rgbhsv_pkg::K_W'(k_full);
    end

    // Advance the stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_reg <= '0;
        end
        else
        begin
            ext_reg <= ext_next;
        end
    end

    assign ext = ext_reg;

endmodule

// ===== sv/rgbhsv_divider.sv =====
// Pipelined reciprocal divider for an 8-bit divisor, exact floor quotient.
`timescale 1ns / 1ps

module rgbhsv_divider
#(
    parameter int NUM_W = 20,
    parameter int QUO_W = 13
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] num,
    input  logic [7:0]       den,
    output logic             out_valid,
    output logic [QUO_W-1:0] quo
);

    localparam int PROD_W = NUM_W + 32;
    localparam int QD_W   = QUO_W + 8;

    // Stage a: operands and reciprocal
    logic             a_valid_reg;
    logic [NUM_W-1:0] a_num_reg;
    logic [7:0]       a_den_reg;
    logic [31:0]      a_rec_reg;

    // Stage b: estimated quotient
    logic             b_valid_reg;
    logic [NUM_W-1:0] b_num_reg;
    logic [7:0]       b_den_reg;
    logic [QUO_W-1:0] b_q0_reg;
    logic [PROD_W-1:0] b_prod;

    // Stage c: back-multiplied estimate
    logic             c_valid_reg;
    logic [NUM_W-1:0] c_num_reg;
    logic [7:0]       c_den_reg;
    logic [QUO_W-1:0] c_q0_reg;
    logic [QD_W-1:0]  c_qd_reg;

    // Stage d: corrected quotient
    logic             d_valid_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [QUO_W-1:0] quo_next;
    logic [NUM_W-1:0] rem;

    // Estimate low by at most one: numerator times reciprocal
    assign b_prod = {{32{1'b0}}, a_num_reg} * {{NUM_W{1'b0}}, a_rec_reg};

    // Bump the estimate when the remainder still holds a divisor; zero divisor gives zero
    always_comb
    begin
        rem = c_num_reg - NUM_W'(c_qd_reg);
        if (c_den_reg == 8'd0)
        begin
            quo_next = '0;
        end
        else if (rem >= NUM_W'(c_den_reg))
        begin
            quo_next = c_q0_reg + QUO_W'(1);
        end
        else
        begin
            quo_next = c_q0_reg;
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        a_num_reg <= num;
        a_den_reg <= den;
        a_rec_reg <= rgbhsv_pkg::RECIP_TAB[den];
        b_num_reg <= a_num_reg;
        b_den_reg <= a_den_reg;
        b_q0_reg  <= b_prod[32 +: QUO_W];
        c_num_reg <= b_num_reg;
        c_den_reg <= b_den_reg;
        c_q0_reg  <= b_q0_reg;
        c_qd_reg  <= {{8{1'b0}}, b_q0_reg} * {{QUO_W{1'b0}}, b_den_reg};
        quo_reg   <= quo_next;
    end

    assign out_valid = d_valid_reg;
    assign quo       = quo_reg;

endmodule

// ===== sv/rgb_to_hsv_converter.sv =====
// Top level of the pipelined RGB to HSV converter.
`timescale 1ns / 1ps

// One packed color enters per clock while start is high; busy never rises, since the
// pipeline does not stall. Each result appears on hue, saturation and brightness with
// done high for one cycle, after its color has passed the channel compare register and
// the reciprocal dividers (table lookup, quotient estimate, back-multiply, one-step
// correction). The receiver cannot stall, so a result must be captured in the cycle
// that done is high. Throughput is one color per clock.

module rgb_to_hsv_converter
#(
    parameter int HUE_FRAC_BITS = 6,
    parameter int SAT_FRAC_BITS = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] color_word,
    output logic        done,
    output logic [14:0] hue,
    output logic [12:0] saturation,
    output logic [7:0]  brightness
);

    localparam int HUE_UNIT = 60 * (1 << HUE_FRAC_BITS);
    localparam int HN_W     = rgbhsv_pkg::K_W + $clog2(HUE_UNIT + 1);
    localparam int HQ_W     = $clog2(360 * (1 << HUE_FRAC_BITS));
    localparam int SN_W     = 8 + SAT_FRAC_BITS;
    localparam int SQ_W     = SAT_FRAC_BITS + 1;
    localparam int DIV_LAT  = 4;

    rgbhsv_pkg::ext_t ext;
    logic [HN_W-1:0]  hue_num;
    logic [SN_W-1:0]  sat_num;
    logic             hue_valid;
    logic             sat_valid;
    logic [HQ_W-1:0]  hue_q;
    logic [SQ_W-1:0]  sat_q;
    logic [7:0]       bright_reg [DIV_LAT];

    assign busy = 1'b0;

    // Compare channels on each accepted transaction
    rgbhsv_extract u_extract
    (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (start && !busy),
        .red   (color_word[31:24]),
        .green (color_word[23:16]),
        .blue  (color_word[15:8]),
        .ext   (ext)
    );

    // Form the numerators: hue in fractional degrees, saturation scaled spread
    assign hue_num = {{(HN_W - rgbhsv_pkg::K_W){1'b0}}, ext.k} * HN_W'(HUE_UNIT);
    assign sat_num = {ext.delta, {SAT_FRAC_BITS{1'b0}}};

    rgbhsv_divider #(.NUM_W(HN_W), .QUO_W(HQ_W)) u_hue_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ext.valid),
        .num       (hue_num),
        .den       (ext.delta),
        .out_valid (hue_valid),
        .quo       (hue_q)
    );

    rgbhsv_divider #(.NUM_W(SN_W), .QUO_W(SQ_W)) u_sat_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ext.valid),
        .num       (sat_num),
        .den       (ext.mx),
        .out_valid (sat_valid),
        .quo       (sat_q)
    );

    // Delay the maximum to line up with the divider results
    always_ff @(posedge clk)
    begin
        bright_reg[0] <= ext.mx;
        for (int i = 1; i < DIV_LAT; i++)
        begin
            bright_reg[i] <= bright_reg[i-1];
        end
    end

    assign done       = hue_valid;
    assign hue        = 15'(hue_q);
    assign saturation = 13'(sat_q);
    assign brightness = bright_reg[DIV_LAT-1];

    // Every accepted transaction returns a result on done
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##5 done)
        else $error("result missing five cycles after accept");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 5))
        else $error("result without a matching accept");

    a_div_align: assert property (@(posedge clk) disable iff (!rst_n)
        hue_valid == sat_valid)
        else $error("hue and saturation dividers out of step");

    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        (done && brightness == 8'd0) |-> (hue == 15'd0 && saturation == 13'd0))
        else $error("black pixel with nonzero hue or saturation");

endmodule

// ===== test/rgb_to_hsv_checker.sv =====
// Checker for the RGB to HSV converter: predicts each color's hue, saturation and value.
`timescale 1ns / 1ps

module rgb_to_hsv_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [31:0] color_word,
    input  logic        done,
    input  logic [14:0] hue,
    input  logic [12:0] saturation,
    input  logic [7:0]  brightness,
    output int          fail_count,
    output int          pending_count
);

    localparam int HUE_FRAC   = 6;
    localparam int SAT_FRAC   = 12;
    localparam int HUE_UNIT   = 60 << HUE_FRAC;
    localparam int PRINT_CAP  = 40;

    typedef enum logic [1:0] {SECTOR_RED, SECTOR_GREEN, SECTOR_BLUE} sector_t;

    typedef struct packed {
        logic [31:0] color;
        logic [14:0] hue;
        logic [12:0] saturation;
        logic [7:0]  brightness;
    } hsv_t;

    hsv_t hsv_expected_q [$];
    int   mismatch_count = 0;
    int   outstanding    = 0;

    assign fail_count    = mismatch_count;
    assign pending_count = outstanding;

    // Print one line (up to a cap) and count the failure
    task automatic report_failure(input string msg);
        if (mismatch_count < PRINT_CAP)
        begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    // Compute the exact hue, saturation and value of one packed color
    function automatic hsv_t predict_hsv(input logic [31:0] word);
        int unsigned r;
        int unsigned g;
        int unsigned b;
        int unsigned mx;
        int unsigned mn;
        int unsigned delta;
        longint      diff;
        longint      base;
        longint      total;
        sector_t     sector;
        hsv_t        res;
        r = 32'(word[31:24]);
        g = 32'(word[23:16]);
        b = 32'(word[15:8]);
        mx = (r > g) ? r : g;
        mx = (mx > b) ? mx : b;
        mn = (r < g) ? r : g;
        mn = (mn < b) ? mn : b;
        delta = mx - mn;
        res.color      = word;
        res.brightness = 8'(mx);
        res.saturation = (mx == 0) ? '0 : 13'((longint'(delta) << SAT_FRAC) / mx);
        res.hue        = '0;
        if (delta != 0)
        begin
            // Ties go to red first, then green
            if (mx == r)
                sector = SECTOR_RED;
            else if (mx == g)
                sector = SECTOR_GREEN;
            else
                sector = SECTOR_BLUE;
            case (sector)
                SECTOR_RED:
                begin
                    diff = longint'(g) - longint'(b);
                    base = (diff < 0) ? 6 : 0;
                end
                SECTOR_GREEN:
                begin
                    diff = longint'(b) - longint'(r);
                    base = 2;
                end
                default:
                begin
                    diff = longint'(r) - longint'(g);
                    base = 4;
                end
            endcase
            // Wrap is folded in before the divide, so the quotient is a floor
            total = HUE_UNIT * diff + base * HUE_UNIT * longint'(delta);
            if (total < 0)
                total = 0;
            res.hue = 15'(total / longint'(delta));
        end
        return res;
    endfunction

    // Compare each result with the oldest prediction, then queue new colors
    always @(posedge clk or negedge rst_n)
    begin
        hsv_t want;
        if (!rst_n)
        begin
            hsv_expected_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (done)
            begin
                if (hsv_expected_q.size() == 0)
                begin
                    report_failure($sformatf("unexpected result hue=%0d sat=%0d val=%0d",
                                             hue, saturation, brightness));
                end
                else
                begin
                    want = hsv_expected_q.pop_front();
                    if (hue !== want.hue)
                        report_failure($sformatf("color %08h: hue %0d, expected %0d",
                                                 want.color, hue, want.hue));
                    if (saturation !== want.saturation)
                        report_failure($sformatf("color %08h: saturation %0d, expected %0d",
                                                 want.color, saturation, want.saturation));
                    if (brightness !== want.brightness)
                        report_failure($sformatf("color %08h: brightness %0d, expected %0d",
                                                 want.color, brightness, want.brightness));
                end
            end
            if (start && !busy)
            begin
                hsv_expected_q.push_back(predict_hsv(color_word));
            end
            outstanding <= hsv_expected_q.size();
        end
    end

endmodule

// ===== test/tb_rgb_to_hsv_converter.sv =====
// Testbench top for the RGB to HSV converter: clock, reset, color stimulus and verdict.
`timescale 1ns / 1ps

module tb_rgb_to_hsv_converter;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_COLORS = 900;
    localparam int CALM_TAIL     = 150;
    localparam int SETTLE_CYCLES = 12;
    localparam int NUM_DIRECTED  = 22;

    // Extremes, every hue sector, ties, gray, black, red wrap and low-byte noise
    localparam logic [31:0] DIRECTED_COLORS [NUM_DIRECTED] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h8080_805A, 32'hFF00_0000,
        32'h00FF_0000, 32'h0000_FF00, 32'hFFFF_0000, 32'h00FF_FF00,
        32'hFF00_FF00, 32'hFF00_0100, 32'hFF01_0000, 32'h0100_0000,
        32'h0001_0000, 32'h0000_01FF, 32'h1234_56FF, 32'h1234_5600,
        32'hFE01_FF00, 32'h01FE_FF00, 32'hFEFF_0100, 32'h7F80_8100,
        32'h0101_0100, 32'hFF80_80AA
    };

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        start      = 1'b0;
    logic [31:0] color_word = '0;
    logic        busy;
    logic        done;
    logic [14:0] hue;
    logic [12:0] saturation;
    logic [7:0]  brightness;
    int          fail_count;
    int          pending_count;
    int          cycle_count = 0;

    rgb_to_hsv_converter DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .color_word (color_word),
        .done       (done),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness)
    );

    rgb_to_hsv_checker hsv_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .color_word    (color_word),
        .done          (done),
        .hue           (hue),
        .saturation    (saturation),
        .brightness    (brightness),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Present one color and hold it until the converter takes the transaction
    task automatic send_color(input logic [31:0] word);
        start      <= 1'b1;
        color_word <= word;
        @(negedge clk);
        while (busy)
        begin
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    // Drop start for a burst of cycles with noise on the data port
    task automatic idle_burst(input int cycles);
        start      <= 1'b0;
        color_word <= $urandom();
        repeat (cycles) @(posedge clk);
    endtask

    // Hold off until every predicted result has come back
    task automatic drain_results();
        start <= 1'b0;
        @(negedge clk);
        while (pending_count != 0)
        begin
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    // Mix of random colors, grays, tied maxima and channel extremes
    function automatic logic [31:0] random_color();
        logic [7:0] ch [3];
        logic [7:0] top;
        int         pick;
        ch[0] = 8'($urandom());
        ch[1] = 8'($urandom());
        ch[2] = 8'($urandom());
        case ($urandom_range(0, 9))
            6:
            begin
                ch[1] = ch[0];
                ch[2] = ch[0];
            end
            7:
            begin
                top  = 8'($urandom_range(1, 255));
                pick = $urandom_range(0, 2);
                foreach (ch[i])
                    ch[i] = (i == pick) ? 8'($urandom_range(0, top)) : top;
            end
            8:
            begin
                foreach (ch[i])
                    ch[i] = ($urandom_range(0, 1) == 1) ? 8'(254 + $urandom_range(0, 1))
                                                        : 8'($urandom_range(0, 1));
            end
            9:
            begin
                ch[$urandom_range(0, 2)] = 8'hFF;
            end
            default:
            begin
            end
        endcase
        return {ch[0], ch[1], ch[2], 8'($urandom())};
    endfunction

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners
        foreach (DIRECTED_COLORS[i])
            send_color(DIRECTED_COLORS[i]);
        drain_results();

        // Random colors with idle bursts and a drain halfway, then a calm tail at full rate
        for (int i = 0; i < RANDOM_COLORS; i++)
        begin
            if (i == RANDOM_COLORS / 2)
                drain_results();
            else if (i < RANDOM_COLORS - CALM_TAIL && $urandom_range(0, 5) == 0)
                idle_burst($urandom_range(1, 16));
            send_color(random_color());
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/rgbhsv_pkg.sv
sv/rgbhsv_extract.sv
sv/rgbhsv_divider.sv
sv/rgb_to_hsv_converter.sv
test/rgb_to_hsv_checker.sv
test/tb_rgb_to_hsv_converter.sv
